// File: src/hcbc_pkg.sv
// Shared constants, widths and helpers for the HSV color blob centroid tracker.
// No dependencies; used by hcbc_div and hsv_color_blob_centroid.
package hcbc_pkg;

   localparam int MAX_OBJECTS  = 4;
   localparam int FRAME_WIDTH  = 1024;
   localparam int FRAME_HEIGHT = 1024;

   localparam int OBJ_W   = 2;            // object index width
   localparam int NUM_W   = 30;           // divider dividend width
   localparam int DEN_W   = 20;           // divider divisor width
   localparam int STEP_W  = 5;            // divider step counter width
   localparam int SUM_W   = 30;
   localparam int CNT_W   = 20;
   localparam int RANGE_W = 46;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // register indexes
   localparam logic [2:0] REG_ENABLE   = 3'd0;
   localparam logic [2:0] REG_NUM_OBJ  = 3'd1;
   localparam logic [2:0] REG_RANGE0   = 3'd2;
   localparam logic [2:0] REG_RANGE3   = 3'd5;

   // result kinds
   localparam logic KIND_PIXEL    = 1'b0;
   localparam logic KIND_CENTROID = 1'b1;

   // floor(c*100/255) via reciprocal: floor(p/255) = (p + 1 + (p >> 8)) >> 8
   function automatic logic [6:0] scale100(input logic [7:0] c);
      logic [15:0] p;
      logic [15:0] t;
      p = 16'(c) * 16'd100;
      t = p + 16'd1 + (p >> 8);
      return t[14:8];
   endfunction

endpackage

// File: src/hcbc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses hcbc_pkg widths. Divide by zero gives all ones; callers mask it.
module hcbc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hcbc_pkg::NUM_W-1:0]    num,
   input  logic [hcbc_pkg::DEN_W-1:0]    den,
   output logic                          done,
   output logic [hcbc_pkg::NUM_W-1:0]    quo
);

   logic [hcbc_pkg::DEN_W-1:0]  rem_ff;
   logic [hcbc_pkg::NUM_W-1:0]  quo_ff;
   logic [hcbc_pkg::DEN_W-1:0]  den_ff;
   logic [hcbc_pkg::STEP_W-1:0] step_ff;
   logic                        run_ff;
   logic                        done_ff;

   logic [hcbc_pkg::DEN_W:0]    trial;
   logic                        fits;
   logic [hcbc_pkg::DEN_W:0]    diff;

   assign trial = {rem_ff, quo_ff[hcbc_pkg::NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= hcbc_pkg::STEP_W'(hcbc_pkg::NUM_W - 1);
         end else if (run_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= fits ? diff[hcbc_pkg::DEN_W-1:0] : trial[hcbc_pkg::DEN_W-1:0];
         quo_ff <= {quo_ff[hcbc_pkg::NUM_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: src/hsv_color_blob_centroid.sv
// HSV color blob centroid tracker: an unclassified pixel goes from item accept to result
// via ST_PREP and ST_PIX; a classified one also waits on the 30-step bit-serial divide.
// One item at a time, via the two shared dividers: the next item is accepted only once the
// pixel result is loaded and, on frame end, each active object's centroid is emitted.
// Reset (synchronous, active high): store cleared, tracking_enable=1, num_objects=1,
// windows 0, no result pending.
module hsv_color_blob_centroid (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // pixel_x, pixel_y, red, green, blue, bg_red, bg_green,
                                   // bg_blue, zero pad
   input  logic        req_tlast,  // frame_end
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // out_red, out_green, out_blue, object_index,
                                   // centroid_x, centroid_y, zero pad
   output logic        rsp_tuser,  // result_kind
   output logic        rsp_tlast,  // last_result
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [45:0] csr_data
);

   localparam int OW = hcbc_pkg::OBJ_W;
   localparam int NO = hcbc_pkg::MAX_OBJECTS;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;  // wait for an item
   localparam logic [2:0] ST_PREP = 3'd1;  // max/min/delta, launch HSV divides
   localparam logic [2:0] ST_HDIV = 3'd2;  // wait hue/sat divide, then accumulate
   localparam logic [2:0] ST_PIX  = 3'd3;  // emit pixel result
   localparam logic [2:0] ST_CDIV = 3'd4;  // centroid divide for object k
   localparam logic [2:0] ST_CENT = 3'd5;  // emit centroid of object k

   logic [2:0] state_ff;

   // configuration
   logic                          enable_ff;
   logic [2:0]                    num_obj_ff;
   logic [hcbc_pkg::RANGE_W-1:0]  range_ff [NO];

   // accumulators
   logic [hcbc_pkg::SUM_W-1:0]    sum_x_ff [NO];
   logic [hcbc_pkg::SUM_W-1:0]    sum_y_ff [NO];
   logic [hcbc_pkg::CNT_W-1:0]    count_ff [NO];

   // item being worked on
   logic [9:0] x_ff, y_ff;
   logic [7:0] r_ff, g_ff, b_ff;
   logic [6:0] sr_ff, sg_ff, sb_ff;
   logic       same_ff, fend_ff, classify_ff;
   logic [6:0] mx_ff, d_ff;
   logic [OW-1:0] k_ff;

   // output register
   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;
   logic        rsp_user_ff, rsp_last_ff;

   // active object count, clamped to 1..MAX_OBJECTS
   logic [3:0] n_act;
   always_comb begin
      priority if (num_obj_ff == 3'd0)            n_act = 4'd1;
      else if (4'(num_obj_ff) > 4'(NO))           n_act = 4'(NO);
      else                                        n_act = 4'(num_obj_ff);
   end

   // input unpack
   logic [9:0] in_x, in_y;
   logic [7:0] in_r, in_g, in_b, in_br, in_bg, in_bb;
   logic       in_same, in_inside;
   assign in_x  = req_tdata[9:0];
   assign in_y  = req_tdata[19:10];
   assign in_r  = req_tdata[27:20];
   assign in_g  = req_tdata[35:28];
   assign in_b  = req_tdata[43:36];
   assign in_br = req_tdata[51:44];
   assign in_bg = req_tdata[59:52];
   assign in_bb = req_tdata[67:60];
   assign in_same   = (in_r == in_br) && (in_g == in_bg) && (in_b == in_bb);
   assign in_inside = (13'(in_x) < 13'(hcbc_pkg::FRAME_WIDTH)) &&
                      (13'(in_y) < 13'(hcbc_pkg::FRAME_HEIGHT));

   // max / min / delta and hue numerator on scaled channels
   logic [6:0]  mx, mn, dd;
   logic [15:0] hnum;
   always_comb begin
      mx = sr_ff;
      mn = sr_ff;
      if (sg_ff > mx) mx = sg_ff;
      if (sb_ff > mx) mx = sb_ff;
      if (sg_ff < mn) mn = sg_ff;
      if (sb_ff < mn) mn = sb_ff;
      dd = mx - mn;
      // modular 16-bit arithmetic; true value is below 36000
      priority if (mx == sg_ff)
         hnum = 16'd120 * 16'(dd) + 16'd60 * 16'(sb_ff) - 16'd60 * 16'(sr_ff);
      else if (mx == sb_ff)
         hnum = 16'd240 * 16'(dd) + 16'd60 * 16'(sr_ff) - 16'd60 * 16'(sg_ff);
      else if (sg_ff >= sb_ff)
         hnum = 16'd60 * 16'(sg_ff - sb_ff);
      else
         hnum = 16'd360 * 16'(dd) - 16'd60 * 16'(sb_ff - sg_ff);
   end

   // shared dividers: sat/hue during classification, x/y during centroid report
   logic                        div_start;
   logic [hcbc_pkg::NUM_W-1:0]  div0_num, div1_num;
   logic [hcbc_pkg::DEN_W-1:0]  div0_den, div1_den;
   logic                        div0_done, div1_done;
   logic [hcbc_pkg::NUM_W-1:0]  div0_quo, div1_quo;
   logic [OW-1:0]               k_sel;

   hcbc_div u_div0 (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div0_num), .den (div0_den), .done (div0_done), .quo (div0_quo)
   );

   hcbc_div u_div1 (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div1_num), .den (div1_den), .done (div1_done), .quo (div1_quo)
   );

   logic out_free;
   logic k_last;
   logic rsp_load;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign k_last   = (4'(k_ff) + 4'd1) == n_act;
   // a new result goes into the output register this cycle
   assign rsp_load = out_free && ((state_ff == ST_PIX) || (state_ff == ST_CENT));

   always_comb begin
      div_start = 1'b0;
      k_sel     = '0;
      unique case (state_ff)
         ST_PREP: div_start = classify_ff;
         ST_PIX:  div_start = out_free && fend_ff;
         ST_CENT: begin
            div_start = out_free && !k_last;
            k_sel     = k_ff + 1'b1;
         end
         default: div_start = 1'b0;
      endcase
      if (state_ff == ST_PREP) begin
         div0_num = hcbc_pkg::NUM_W'(16'd100 * 16'(dd));
         div0_den = hcbc_pkg::DEN_W'(mx);
         div1_num = hcbc_pkg::NUM_W'(hnum);
         div1_den = hcbc_pkg::DEN_W'(dd);
      end else begin
         div0_num = sum_x_ff[k_sel];
         div0_den = count_ff[k_sel];
         div1_num = sum_y_ff[k_sel];
         div1_den = count_ff[k_sel];
      end
   end

   // hue and saturation with the zero cases masked
   logic [8:0] hue;
   logic [6:0] sat;
   assign hue = (d_ff == '0)  ? 9'd0 : div1_quo[8:0];
   assign sat = (mx_ff == '0) ? 7'd0 : div0_quo[6:0];

   logic [NO-1:0] hit;
   always_comb begin
      for (int i = 0; i < NO; i++) begin
         hit[i] = (range_ff[i][8:0]   <= hue)   && (hue   <= range_ff[i][17:9]) &&
                  (range_ff[i][24:18] <= sat)   && (sat   <= range_ff[i][31:25]) &&
                  (range_ff[i][38:32] <= mx_ff) && (mx_ff <= range_ff[i][45:39]) &&
                  (4'(i) < n_act) && (count_ff[i] != hcbc_pkg::CNT_MAX);
      end
   end

   logic [hcbc_pkg::SUM_W:0] add_x [NO];
   logic [hcbc_pkg::SUM_W:0] add_y [NO];
   always_comb begin
      for (int i = 0; i < NO; i++) begin
         add_x[i] = {1'b0, sum_x_ff[i]} + (hcbc_pkg::SUM_W+1)'(x_ff);
         add_y[i] = {1'b0, sum_y_ff[i]} + (hcbc_pkg::SUM_W+1)'(y_ff);
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b1;
         num_obj_ff <= 3'd1;
         for (int i = 0; i < NO; i++) range_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            hcbc_pkg::REG_ENABLE:  enable_ff  <= csr_data[0];
            hcbc_pkg::REG_NUM_OBJ: num_obj_ff <= csr_data[2:0];
            default: begin
               for (int i = 0; i < NO; i++)
                  if (csr_index == hcbc_pkg::REG_RANGE0 + 3'(i)) range_ff[i] <= csr_data;
            end
         endcase
      end
   end

   // sequencer, accumulators and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         for (int i = 0; i < NO; i++) begin
            sum_x_ff[i] <= '0;
            sum_y_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (rsp_tready && !rsp_load) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  x_ff        <= in_x;
                  y_ff        <= in_y;
                  r_ff        <= in_r;
                  g_ff        <= in_g;
                  b_ff        <= in_b;
                  sr_ff       <= hcbc_pkg::scale100(in_r);
                  sg_ff       <= hcbc_pkg::scale100(in_g);
                  sb_ff       <= hcbc_pkg::scale100(in_b);
                  same_ff     <= in_same;
                  fend_ff     <= req_tlast;
                  classify_ff <= !in_same && enable_ff && in_inside;
                  state_ff    <= ST_PREP;
               end
            end
            ST_PREP: begin
               mx_ff    <= mx;
               d_ff     <= dd;
               state_ff <= classify_ff ? ST_HDIV : ST_PIX;
            end
            ST_HDIV: begin
               if (div0_done && div1_done) begin
                  for (int i = 0; i < NO; i++) begin
                     if (hit[i]) begin
                        sum_x_ff[i] <= add_x[i][hcbc_pkg::SUM_W] ? hcbc_pkg::SUM_MAX
                                                                 : add_x[i][hcbc_pkg::SUM_W-1:0];
                        sum_y_ff[i] <= add_y[i][hcbc_pkg::SUM_W] ? hcbc_pkg::SUM_MAX
                                                                 : add_y[i][hcbc_pkg::SUM_W-1:0];
                        count_ff[i] <= count_ff[i] + 1'b1;
                     end
                  end
                  state_ff <= ST_PIX;
               end
            end
            ST_PIX: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= hcbc_pkg::KIND_PIXEL;
                  rsp_last_ff  <= !fend_ff;
                  rsp_data_ff  <= same_ff ? 48'd0 : {24'd0, b_ff, g_ff, r_ff};
                  k_ff         <= '0;
                  state_ff     <= fend_ff ? ST_CDIV : ST_IDLE;
               end
            end
            ST_CDIV: begin
               if (div0_done && div1_done) state_ff <= ST_CENT;
            end
            ST_CENT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= hcbc_pkg::KIND_CENTROID;
                  rsp_last_ff  <= k_last;
                  rsp_data_ff  <= (count_ff[k_ff] == '0)
                                  ? {22'd0, k_ff, 24'd0}
                                  : {2'd0, div1_quo[9:0], div0_quo[9:0], k_ff, 24'd0};
                  if (k_last) begin
                     // frame done: clear the store
                     for (int i = 0; i < NO; i++) begin
                        sum_x_ff[i] <= '0;
                        sum_y_ff[i] <= '0;
                        count_ff[i] <= '0;
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= ST_CDIV;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
